### rtl/ppt_pkg.sv
// ppt_pkg: widths, constants and helper functions for the period tachometer
// used by pulse_period_tachometer_core; depends on nothing else
package ppt_pkg;

	localparam int SAMPLE_BUFFER_SIZE = 16;

	localparam int IDX_W   = (SAMPLE_BUFFER_SIZE > 1) ? $clog2(SAMPLE_BUFFER_SIZE) : 1;
	localparam int CNT_W   = $clog2(SAMPLE_BUFFER_SIZE + 1);
	localparam int RPM_W   = 26;
	localparam int TIME_W  = 32;
	localparam int SUM_W   = RPM_W + $clog2(SAMPLE_BUFFER_SIZE);
	localparam int DIV_W   = SUM_W;
	localparam int DCNT_W  = $clog2(DIV_W);

	localparam int RPM_NUMERATOR = 60000000;
	localparam int MAP_IN_LOW    = 60;
	localparam int MAP_IN_HIGH   = 100000;
	localparam int MAP_SPAN      = MAP_IN_HIGH - MAP_IN_LOW;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(1000000);

	localparam logic FUNC_PULSE  = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	// lowest rpm that maps to window index k
	function automatic logic [RPM_W-1:0] window_threshold(input int k);
		int t;
		begin
			t = MAP_IN_LOW + (k * MAP_SPAN + SAMPLE_BUFFER_SIZE - 1) / SAMPLE_BUFFER_SIZE;
			return RPM_W'(t);
		end
	endfunction

	// map of rpm over 60..100000 onto 0..size-1, capped at the top
	function automatic logic [IDX_W-1:0] rpm_window(input logic [RPM_W-1:0] rpm);
		logic [IDX_W-1:0] cnt;
		begin
			cnt = '0;
			for (int k = 1; k < SAMPLE_BUFFER_SIZE; k++) begin
				if (rpm >= window_threshold(k))
					cnt = cnt + IDX_W'(1);
			end
			return cnt;
		end
	endfunction

endpackage

### rtl/pulse_period_tachometer_core.sv
// pulse_period_tachometer_core: period based tachometer with windowed average
// depends on ppt_pkg; holds the reading memory and the shared serial divider

// Each item is a pulse event or an update poll and yields one result. A pulse
// event and an update poll that takes no reading go straight to ST_DONE and
// reach the output register once it is free. An update poll that takes a
// reading runs the shared restoring divider to get rpm, stores the reading and
// derives the window in ST_STORE, checks in ST_CHECK whether the window closes,
// and if it does reads back window_last + 1 readings from the reading memory at
// one per cycle and runs the divider again for the average. A new item is taken
// once the previous one has reached the output register, even if that result
// still waits there. The reading memory needs no clearing pass: per entry valid
// bits make unwritten entries read as zero.
module pulse_period_tachometer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ppt_pkg::TIME_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [ppt_pkg::TIME_W-1:0]  now_us,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ppt_pkg::RPM_W-1:0]   rpm_average,
	output logic                        timed_out,
	output logic                        average_updated
);
	import ppt_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_DIV_RPM = 7'b0000010,
		ST_STORE   = 7'b0000100,
		ST_CHECK   = 7'b0001000,
		ST_SUM     = 7'b0010000,
		ST_DIV_AVG = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	state_t state_q;

	logic [TIME_W-1:0]  timeout_q;
	logic [TIME_W-1:0]  last_q;
	logic [TIME_W-1:0]  period_q;
	logic               flag_q;
	logic               pending_q;
	logic [IDX_W-1:0]   sample_q;
	logic [IDX_W-1:0]   win_q;
	logic [CNT_W-1:0]   nxt_idx_q;
	logic [RPM_W-1:0]   avg_q;
	logic               upd_q;

	// reading memory and its valid bits
	logic [RPM_W-1:0]   mem [SAMPLE_BUFFER_SIZE];
	logic [SAMPLE_BUFFER_SIZE-1:0] valid_q;
	logic [RPM_W-1:0]   rd_data_s1;
	logic               rd_ok_s1;
	logic               rd_vld_s1;
	logic [CNT_W-1:0]   rd_addr_q;
	logic [SUM_W-1:0]   sum_q;
	logic               rd_go;
	logic               mem_we;
	logic [RPM_W-1:0]   rpm_new;

	// serial divider
	logic [TIME_W-1:0]  div_rem_q;
	logic [DIV_W-1:0]   div_quo_q;
	logic [TIME_W-1:0]  div_den_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [TIME_W:0]    div_trial;
	logic               div_ge;
	logic [TIME_W:0]    div_diff;
	logic [DIV_W-1:0]   div_quo_next;
	logic               div_last;

	logic               in_xfer;
	logic               out_load;
	logic [TIME_W-1:0]  elapsed;

	logic [RPM_W-1:0]   out_avg_q;
	logic               out_flag_q;
	logic               out_upd_q;
	logic               out_valid_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign elapsed  = now_us - last_q;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign div_trial    = {div_rem_q, div_quo_q[DIV_W-1]};
	assign div_ge       = div_trial >= {1'b0, div_den_q};
	assign div_diff     = div_trial - {1'b0, div_den_q};
	assign div_quo_next = {div_quo_q[DIV_W-2:0], div_ge};
	assign div_last     = (div_cnt_q == DCNT_W'(DIV_W - 1));

	assign rpm_new = div_quo_q[RPM_W-1:0];
	assign mem_we  = (state_q == ST_STORE);
	assign rd_go   = (state_q == ST_SUM) && (rd_addr_q <= CNT_W'(win_q));

	// synchronous reading memory with registered read data
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[sample_q] <= rpm_new;
		rd_data_s1 <= mem[rd_addr_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_ok_s1  <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_we)
				valid_q[sample_q] <= 1'b1;
			rd_ok_s1  <= valid_q[rd_addr_q[IDX_W-1:0]];
			rd_vld_s1 <= rd_go;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TIMEOUT_RESET;
		else if (cfg_we)
			timeout_q <= cfg_wdata;
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			div_rem_q <= '0;
			div_quo_q <= DIV_W'(RPM_NUMERATOR);
			div_den_q <= period_q;
		end else if (state_q == ST_SUM) begin
			div_rem_q <= '0;
			div_quo_q <= sum_q;
			div_den_q <= TIME_W'(win_q) + TIME_W'(1);
		end else if (state_q == ST_DIV_RPM || state_q == ST_DIV_AVG) begin
			div_rem_q <= div_ge ? div_diff[TIME_W-1:0] : div_trial[TIME_W-1:0];
			div_quo_q <= div_quo_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			last_q    <= '0;
			period_q  <= '0;
			flag_q    <= 1'b0;
			pending_q <= 1'b0;
			sample_q  <= '0;
			win_q     <= '0;
			nxt_idx_q <= '0;
			avg_q     <= '0;
			upd_q     <= 1'b0;
			rd_addr_q <= '0;
			sum_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						upd_q     <= 1'b0;
						div_cnt_q <= '0;
						state_q   <= ST_DONE;
						if (func == FUNC_PULSE) begin
							period_q  <= elapsed;
							last_q    <= now_us;
							flag_q    <= 1'b0;
							pending_q <= 1'b1;
						end else begin
							pending_q <= 1'b0;
							if (elapsed > timeout_q && !flag_q && !pending_q) begin
								flag_q   <= 1'b1;
								avg_q    <= '0;
								sample_q <= '0;
							end else if (!flag_q && pending_q && period_q != '0) begin
								state_q <= ST_DIV_RPM;
							end
						end
					end
				end
				ST_DIV_RPM: begin
					div_cnt_q <= div_cnt_q + DCNT_W'(1);
					if (div_last)
						state_q <= ST_STORE;
				end
				ST_STORE: begin
					win_q     <= rpm_window(rpm_new);
					nxt_idx_q <= CNT_W'(sample_q) + CNT_W'(1);
					state_q   <= ST_CHECK;
				end
				ST_CHECK: begin
					if (nxt_idx_q > CNT_W'(win_q)) begin
						sample_q  <= '0;
						rd_addr_q <= '0;
						sum_q     <= '0;
						state_q   <= ST_SUM;
					end else begin
						sample_q <= nxt_idx_q[IDX_W-1:0];
						state_q  <= ST_DONE;
					end
				end
				ST_SUM: begin
					if (rd_go)
						rd_addr_q <= rd_addr_q + CNT_W'(1);
					if (rd_vld_s1 && rd_ok_s1)
						sum_q <= sum_q + SUM_W'(rd_data_s1);
					if (!rd_go && !rd_vld_s1) begin
						div_cnt_q <= '0;
						state_q   <= ST_DIV_AVG;
					end
				end
				ST_DIV_AVG: begin
					div_cnt_q <= div_cnt_q + DCNT_W'(1);
					if (div_last) begin
						avg_q   <= div_quo_next[RPM_W-1:0];
						upd_q   <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register parts the result from the next item's work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q  <= avg_q;
			out_flag_q <= flag_q;
			out_upd_q  <= upd_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign rpm_average     = out_avg_q;
	assign timed_out       = out_flag_q;
	assign average_updated = out_upd_q;

`ifndef ASSERT_OFF
	// a new average never comes with the timeout flag set
	a_upd_not_timed_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(average_updated && timed_out))
		else $error("average update reported while timed out");

	// after a timeout the speed reads zero
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> rpm_average == '0)
		else $error("nonzero speed while timed out");

	// one item at a time: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// divider count stays inside its iteration range
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_RPM || state_q == ST_DIV_AVG) |->
			div_cnt_q <= DCNT_W'(DIV_W - 1))
		else $error("divider ran past its last step");
`endif

endmodule

### bench/testbench.sv
// testbench for pulse_period_tachometer_core: directed and random pulse/update
// traffic checked against a behavioral tachometer model; depends on ppt_pkg
`timescale 1ns / 100ps

module testbench;
	import ppt_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 400;
	localparam int PHASE_ITEMS = 215;

	typedef struct packed {
		logic [RPM_W-1:0] rpm;
		logic             tmo;
		logic             upd;
	} readout_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [TIME_W-1:0]  cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               func = FUNC_PULSE;
	logic [TIME_W-1:0]  now_us = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [RPM_W-1:0]   rpm_average;
	logic               timed_out;
	logic               average_updated;

	// tachometer model state
	logic [TIME_W-1:0]  tmo_limit_us = TIMEOUT_RESET;
	logic [TIME_W-1:0]  last_edge_us = '0;
	logic [TIME_W-1:0]  edge_period_us = '0;
	logic               lapsed = 1'b0;
	logic               edge_pending = 1'b0;
	logic [RPM_W-1:0]   readings [SAMPLE_BUFFER_SIZE];
	int unsigned        read_idx = 0;
	int unsigned        win_last = 0;
	logic [RPM_W-1:0]   avg_rpm = '0;

	readout_t           expected_readouts[$];
	int                 mismatches = 0;
	int                 cycle_count = 0;
	int                 burst_left = 0;
	logic [TIME_W-1:0]  pulse_clock = '0;

	logic               hold_req = 1'b0;
	int                 hold_left = 0;
	int                 stall_mode = 0;
	int                 mode_left = 0;
	logic [2:0]         stall_phase = '0;

	pulse_period_tachometer_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.now_us          (now_us),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.rpm_average     (rpm_average),
		.timed_out       (timed_out),
		.average_updated (average_updated)
	);

	always #4 clk = ~clk;

	initial begin
		for (int i = 0; i < SAMPLE_BUFFER_SIZE; i++)
			readings[i] = '0;
	end

	// map rpm over 60..100000 onto the window, capped at the last slot
	function automatic int unsigned window_of(logic [RPM_W-1:0] rpm);
		longint unsigned w;
		if (rpm <= MAP_IN_LOW)
			return 0;
		w = (longint'(rpm) - MAP_IN_LOW) * SAMPLE_BUFFER_SIZE / MAP_SPAN;
		if (w > SAMPLE_BUFFER_SIZE - 1)
			w = SAMPLE_BUFFER_SIZE - 1;
		return int'(w);
	endfunction

	function automatic logic store_reading(logic [TIME_W-1:0] period);
		logic [TIME_W-1:0] quo;
		int unsigned       slot;
		longint unsigned   sum;
		quo = RPM_NUMERATOR / period;
		slot = read_idx % SAMPLE_BUFFER_SIZE;
		readings[slot] = quo[RPM_W-1:0];
		win_last = window_of(quo[RPM_W-1:0]);
		read_idx = slot + 1;
		if (read_idx <= win_last)
			return 1'b0;
		sum = 0;
		for (int i = 0; i <= win_last; i++)
			sum += readings[i];
		avg_rpm = RPM_W'(sum / (win_last + 1));
		read_idx = 0;
		return 1'b1;
	endfunction

	function automatic readout_t predict_readout(logic f, logic [TIME_W-1:0] t);
		readout_t          r;
		logic              had_edge;
		logic              upd;
		logic [TIME_W-1:0] elapsed;
		upd = 1'b0;
		if (f == FUNC_PULSE) begin
			edge_period_us = t - last_edge_us;
			last_edge_us = t;
			lapsed = 1'b0;
			edge_pending = 1'b1;
		end else begin
			had_edge = edge_pending;
			edge_pending = 1'b0;
			elapsed = t - last_edge_us;
			if (elapsed > tmo_limit_us && !lapsed && !had_edge) begin
				lapsed = 1'b1;
				avg_rpm = '0;
				read_idx = 0;
			end else if (!lapsed && had_edge && edge_period_us != 0) begin
				upd = store_reading(edge_period_us);
			end
		end
		r.rpm = avg_rpm;
		r.tmo = lapsed;
		r.upd = upd;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// predict on each input transfer, compare on each output transfer
	always @(posedge clk) begin
		readout_t want;
		if (arst_n && in_valid && in_ready)
			expected_readouts.push_back(predict_readout(func, now_us));
		if (arst_n && out_valid && out_ready) begin
			if (expected_readouts.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual rpm %0d tmo %0b upd %0b",
					$time, rpm_average, timed_out, average_updated);
			end else begin
				want = expected_readouts.pop_front();
				check_field("rpm_average", want.rpm, rpm_average);
				check_field("timed_out", want.tmo, timed_out);
				check_field("average_updated", want.upd, average_updated);
			end
		end
	end

	// receiver: long hold on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			hold_left <= LONG_HOLD;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(64, 512);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= (stall_phase < 3'd5);
			endcase
			stall_phase <= stall_phase + 3'd1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) :
				$urandom_range(1, 12);
		end
		burst_left--;
	endtask

	task automatic send_event(logic f, logic [TIME_W-1:0] t);
		pace_sender();
		in_valid <= 1'b1;
		func <= f;
		now_us <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	// wait past the clock edge first so the prediction of the last transfer is queued
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_readouts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(logic [TIME_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tmo_limit_us = value;
	endtask

	task automatic test_directed_cases();
		write_timeout(TIMEOUT_RESET);
		send_event(FUNC_UPDATE, 32'd0);          // nothing pending, nothing lapsed
		send_event(FUNC_PULSE, 32'd0);           // zero period
		send_event(FUNC_UPDATE, 32'd5);
		send_event(FUNC_PULSE, 32'd1);           // fastest edge, widest window
		send_event(FUNC_UPDATE, 32'd2);
		send_event(FUNC_PULSE, 32'hFFFF_FFFF);   // slowest edge, rpm rounds to zero
		send_event(FUNC_UPDATE, 32'hFFFF_FFFF);
		send_event(FUNC_PULSE, 32'd999);         // timestamp wraps
		send_event(FUNC_UPDATE, 32'd1000);
		send_event(FUNC_PULSE, 32'd1999);
		send_event(FUNC_PULSE, 32'd2599);        // a further edge overwrites the period
		send_event(FUNC_UPDATE, 32'd2600);
		send_event(FUNC_UPDATE, 32'd3000);
		send_event(FUNC_UPDATE, 32'd2599 + 32'd1000000);   // exactly at the limit
		send_event(FUNC_UPDATE, 32'd2599 + 32'd1000001);   // just past it
		send_event(FUNC_UPDATE, 32'd2599 + 32'd5000000);   // already lapsed
		send_event(FUNC_PULSE, 32'd6002599);
		send_event(FUNC_UPDATE, 32'd6002600);
		send_event(FUNC_PULSE, 32'd7001599);
		send_event(FUNC_UPDATE, 32'd7001600);
		send_event(FUNC_PULSE, 32'd7001605);
		send_event(FUNC_UPDATE, 32'd7001606);
		wait_idle();
	endtask

	task automatic test_timeout_extremes();
		write_timeout(32'd0);
		send_event(FUNC_PULSE, 32'h8000_0000);
		send_event(FUNC_UPDATE, 32'h8000_0000);
		send_event(FUNC_UPDATE, 32'h8000_0000);
		send_event(FUNC_UPDATE, 32'h8000_0001);
		write_timeout(32'hFFFF_FFFF);
		send_event(FUNC_PULSE, 32'h1234_5678);
		send_event(FUNC_UPDATE, 32'h1234_5682);
		send_event(FUNC_UPDATE, 32'h1234_5677);  // largest possible lapse
		write_timeout(32'd1);
		send_event(FUNC_PULSE, 32'h00F0_0000);
		send_event(FUNC_UPDATE, 32'h00F0_0001);
		send_event(FUNC_UPDATE, 32'h00F0_0001);
		send_event(FUNC_UPDATE, 32'h00F0_0002);
		pulse_clock = 32'h00F0_0002;
		wait_idle();
	endtask

	function automatic logic [TIME_W-1:0] pick_base_period();
		case ($urandom_range(0, 7))
			0:       return $urandom_range(1, 600);
			1, 2:    return $urandom_range(600, 6000);
			3, 4:    return $urandom_range(6000, 60000);
			5:       return $urandom_range(60000, 1000000);
			6:       return $urandom_range(1000000, 100000000);
			default: return $urandom_range(1, 60);
		endcase
	endfunction

	// mostly runs of steady-speed edge/poll pairs, with noise and broken pairs
	task automatic run_random_phase(logic [TIME_W-1:0] limit_us);
		int                count;
		int                seg_left;
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] per;
		logic [TIME_W-1:0] t;
		logic              f;
		write_timeout(limit_us);
		count = 0;
		seg_left = 0;
		base = 1000;
		while (count < PHASE_ITEMS) begin
			if (seg_left == 0) begin
				base = pick_base_period();
				seg_left = $urandom_range(4, 40);
			end
			seg_left--;
			per = base + $urandom_range(0, base >> 3);
			case ($urandom_range(0, 9))
				0: begin
					f = $urandom_range(0, 1);
					t = $urandom();
					send_event(f, t);
					if (f == FUNC_PULSE)
						pulse_clock = t;
					count += 1;
				end
				1: begin
					pulse_clock += per;
					send_event(FUNC_PULSE, pulse_clock);
					if ($urandom_range(0, 1) == 0)
						pulse_clock += per;
					send_event(FUNC_PULSE, pulse_clock);
					send_event(FUNC_UPDATE, pulse_clock + $urandom_range(0, 40));
					count += 3;
				end
				default: begin
					pulse_clock += per;
					send_event(FUNC_PULSE, pulse_clock);
					send_event(FUNC_UPDATE, pulse_clock + $urandom_range(0, 40));
					count += 2;
					case ($urandom_range(0, 15))
						0: begin
							send_event(FUNC_UPDATE,
								pulse_clock + tmo_limit_us + $urandom_range(1, 500));
							count += 1;
						end
						1: begin
							send_event(FUNC_UPDATE, pulse_clock + $urandom_range(41, 200));
							count += 1;
						end
						default: ;
					endcase
				end
			endcase
		end
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		burst_left = 1000;
		hold_req <= 1'b1;
		do @(posedge clk); while (hold_left == 0);
		hold_req <= 1'b0;
		for (int k = 0; k < 15; k++) begin
			pulse_clock += 3000 + k;
			send_event(FUNC_PULSE, pulse_clock);
			send_event(FUNC_UPDATE, pulse_clock + 1);
		end
		burst_left = 0;
		wait_idle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_timeout_extremes();
		run_random_phase(TIMEOUT_RESET);
		test_output_backpressure();
		run_random_phase(32'd1);
		run_random_phase(32'hFFFF_FFFF);
		run_random_phase($urandom_range(1000, 3000000));
		wait_idle();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_readouts.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
rtl/ppt_pkg.sv
rtl/pulse_period_tachometer_core.sv
bench/testbench.sv
